/* hw/rtl/fptw_pkg.sv */
package fptw_pkg;

   localparam int TABLE_PAGES_DEFAULT = 16;
   localparam int ENTRIES_PER_TABLE   = 512;
   localparam int INDEX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_W              = 48;
   localparam int OFFSET_W            = 12;
   localparam int FRAME_W             = ADDR_W - OFFSET_W;
   localparam int ENTRY_W             = 64;
   localparam int HUGE_BIT_POS        = 7;

   localparam logic [ADDR_W-1:0]   POOL_BASE_RESET = 48'h0000_0000_1000;
   localparam logic [OFFSET_W-1:0] LINK_FLAGS      = 12'h003;
   localparam logic [ENTRY_W-1:0]  PRESENT_BIT     = 64'd1;

   localparam logic [1:0] MODE_MAP       = 2'd0;
   localparam logic [1:0] MODE_UNMAP     = 2'd1;
   localparam logic [1:0] MODE_TRANSLATE = 2'd2;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NOPAGE   = 2'd1;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd2;

   localparam logic [1:0] LEVEL_TOP  = 2'd0;
   localparam logic [1:0] LEVEL_LEAF = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_LINK,
      ST_RESP
   } walk_state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [ADDR_W-1:0]  virt_addr;
      logic [ADDR_W-1:0]  phys_addr;
      logic [ENTRY_W-1:0] entry_flags;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] translated_addr;
   } rsp_word_type;

endpackage

/* hw/rtl/fptw_ram.sv */
module fptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/four_level_page_table_walker_top.sv */
// Four-level page table walker over a private pool of TABLE_PAGES table pages held in one
// single-port-write, registered-read RAM; page 0 is the top level. After reset the block
// sweeps the whole RAM to zero, one entry a cycle, and takes no request word until the
// sweep ends (csr writes are taken at any time). Each table level above the leaf is a RAM
// read and then its evaluation, since the next address depends on the entry just read;
// every table page taken from the pool is first cleared, and then the link to it is
// written. The response sits in an output register, so the next request word is accepted
// while the previous response still waits.
module four_level_page_table_walker_top #(
   parameter int TABLE_PAGES = fptw_pkg::TABLE_PAGES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fptw_pkg::req_word_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fptw_pkg::rsp_word_type     rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fptw_pkg::ADDR_W-1:0] csr_data
);

   localparam int PAGE_W  = $clog2(TABLE_PAGES);
   localparam int INDEX_W = fptw_pkg::INDEX_W;
   localparam int MEM_AW  = PAGE_W + INDEX_W;
   localparam int DEPTH   = TABLE_PAGES * fptw_pkg::ENTRIES_PER_TABLE;
   localparam int FRAME_W = fptw_pkg::FRAME_W;
   localparam logic [MEM_AW-1:0] MEM_LAST  = MEM_AW'(DEPTH - 1);
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(TABLE_PAGES - 1);

   fptw_pkg::walk_state_type state_ff, state_in;
   logic [1:0]                  level_ff, level_in;
   logic [PAGE_W-1:0]           page_ff, page_in;
   logic [PAGE_W-1:0]           new_page_ff, new_page_in;
   logic [PAGE_W-1:0]           next_free_ff, next_free_in;
   logic [MEM_AW-1:0]           clr_addr_ff, clr_addr_in;
   logic                        clr_all_ff, clr_all_in;
   logic [MEM_AW-1:0]           link_addr_ff, link_addr_in;
   logic [FRAME_W-1:0]          pool_fn_ff, pool_fn_in;
   fptw_pkg::req_word_type      job_ff, job_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic [fptw_pkg::ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fptw_pkg::rsp_word_type      rsp_ff, rsp_in;

   logic                            wr_en;
   logic [MEM_AW-1:0]               wr_addr;
   logic [fptw_pkg::ENTRY_W-1:0]    wr_data;
   logic                            rd_en;
   logic [fptw_pkg::ENTRY_W-1:0]    rd_data;
   logic [INDEX_W-1:0]              level_index;
   logic [MEM_AW-1:0]               cur_addr;
   logic [FRAME_W-1:0]              ent_fn;
   logic                            ent_zero;
   logic                            ent_huge;
   logic [FRAME_W:0]                link_diff;
   logic                            link_ok;
   logic [FRAME_W-1:0]              link_fn;
   logic [fptw_pkg::ENTRY_W-1:0]    leaf_word;
   logic                            rsp_free;
   logic                            clr_last;

   fptw_ram #(
      .WIDTH (fptw_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_addr),
      .rd_data (rd_data)
   );

   // level index out of the virtual address
   always_comb begin
      case (level_ff)
         2'd0:    level_index = job_ff.virt_addr[47:39];
         2'd1:    level_index = job_ff.virt_addr[38:30];
         2'd2:    level_index = job_ff.virt_addr[29:21];
         default: level_index = job_ff.virt_addr[20:12];
      endcase
   end

   assign cur_addr  = {page_ff, level_index};
   assign ent_fn    = rd_data[fptw_pkg::ADDR_W-1:fptw_pkg::OFFSET_W];
   assign ent_zero  = (ent_fn == '0);
   assign ent_huge  = rd_data[fptw_pkg::HUGE_BIT_POS];
   assign link_diff = {1'b0, ent_fn} - {1'b0, pool_fn_ff};
   assign link_ok   = !link_diff[FRAME_W] && (link_diff[FRAME_W-1:0] < FRAME_W'(TABLE_PAGES));
   assign link_fn   = pool_fn_ff + FRAME_W'(new_page_ff);
   assign leaf_word = {16'b0, job_ff.phys_addr[fptw_pkg::ADDR_W-1:fptw_pkg::OFFSET_W],
                       {fptw_pkg::OFFSET_W{1'b0}}} | job_ff.entry_flags | fptw_pkg::PRESENT_BIT;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = clr_all_ff ? (clr_addr_ff == MEM_LAST)
                                 : (clr_addr_ff[INDEX_W-1:0] == '1);

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      new_page_in   = new_page_ff;
      next_free_in  = next_free_ff;
      clr_addr_in   = clr_addr_ff;
      clr_all_in    = clr_all_ff;
      link_addr_in  = link_addr_ff;
      pool_fn_in    = pool_fn_ff;
      job_in        = job_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      req_ready     = 1'b0;

      if (csr_valid) begin
         pool_fn_in = csr_data[fptw_pkg::ADDR_W-1:fptw_pkg::OFFSET_W];
      end

      case (state_ff)
         fptw_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_last) begin
               clr_all_in = 1'b0;
               state_in   = clr_all_ff ? fptw_pkg::ST_IDLE : fptw_pkg::ST_LINK;
            end
         end
         fptw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               job_in        = req_data;
               level_in      = fptw_pkg::LEVEL_TOP;
               page_in       = '0;
               res_status_in = fptw_pkg::STATUS_UNMAPPED;
               res_addr_in   = '0;
               if (req_data.mode == fptw_pkg::MODE_MAP || req_data.mode == fptw_pkg::MODE_UNMAP ||
                   req_data.mode == fptw_pkg::MODE_TRANSLATE) begin
                  state_in = fptw_pkg::ST_READ;
               end else begin
                  state_in = fptw_pkg::ST_RESP;
               end
            end
         end
         fptw_pkg::ST_READ: begin
            if (level_ff == fptw_pkg::LEVEL_LEAF && job_ff.mode == fptw_pkg::MODE_MAP) begin
               wr_en         = 1'b1;
               wr_addr       = cur_addr;
               wr_data       = leaf_word;
               res_status_in = fptw_pkg::STATUS_DONE;
               state_in      = fptw_pkg::ST_RESP;
            end else if (level_ff == fptw_pkg::LEVEL_LEAF &&
                         job_ff.mode == fptw_pkg::MODE_UNMAP) begin
               wr_en         = 1'b1;
               wr_addr       = cur_addr;
               res_status_in = fptw_pkg::STATUS_DONE;
               state_in      = fptw_pkg::ST_RESP;
            end else begin
               rd_en        = 1'b1;
               link_addr_in = cur_addr;
               state_in     = fptw_pkg::ST_EVAL;
            end
         end
         fptw_pkg::ST_EVAL: begin
            state_in = fptw_pkg::ST_RESP;
            if (level_ff == fptw_pkg::LEVEL_LEAF) begin
               if (!ent_zero) begin
                  res_status_in = fptw_pkg::STATUS_DONE;
                  res_addr_in   = {ent_fn, job_ff.virt_addr[fptw_pkg::OFFSET_W-1:0]};
               end
            end else if (level_ff != fptw_pkg::LEVEL_TOP && ent_huge) begin
               res_status_in = fptw_pkg::STATUS_UNMAPPED;
            end else if (ent_zero) begin
               if (job_ff.mode != fptw_pkg::MODE_MAP) begin
                  res_status_in = fptw_pkg::STATUS_UNMAPPED;
               end else if (next_free_ff == '0) begin
                  res_status_in = fptw_pkg::STATUS_NOPAGE;
               end else begin
                  new_page_in  = next_free_ff;
                  clr_addr_in  = {next_free_ff, {INDEX_W{1'b0}}};
                  clr_all_in   = 1'b0;
                  next_free_in = (next_free_ff == PAGE_LAST) ? '0 : next_free_ff + 1'b1;
                  state_in     = fptw_pkg::ST_CLEAR;
               end
            end else if (link_ok) begin
               page_in  = link_diff[PAGE_W-1:0];
               level_in = level_ff + 1'b1;
               state_in = fptw_pkg::ST_READ;
            end else begin
               res_status_in = fptw_pkg::STATUS_UNMAPPED;
            end
         end
         fptw_pkg::ST_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = link_addr_ff;
            wr_data  = {16'b0, link_fn, fptw_pkg::LINK_FLAGS};
            page_in  = new_page_ff;
            level_in = level_ff + 1'b1;
            state_in = fptw_pkg::ST_READ;
         end
         fptw_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = res_status_ff;
               rsp_in.translated_addr = res_addr_ff;
               state_in               = fptw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fptw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fptw_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_all_ff   <= 1'b1;
         next_free_ff <= PAGE_W'(1);
         pool_fn_ff   <= fptw_pkg::POOL_BASE_RESET[fptw_pkg::ADDR_W-1:fptw_pkg::OFFSET_W];
         rsp_valid_ff <= 1'b0;
         level_ff     <= fptw_pkg::LEVEL_TOP;
         page_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_all_ff   <= clr_all_in;
         next_free_ff <= next_free_in;
         pool_fn_ff   <= pool_fn_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         page_ff      <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      new_page_ff   <= new_page_in;
      link_addr_ff  <= link_addr_in;
      job_ff        <= job_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_ff        <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_link_after_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fptw_pkg::ST_LINK) |-> ($past(state_ff) == fptw_pkg::ST_CLEAR))
      else $error("link write without a preceding page clear");

   a_clear_in_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fptw_pkg::ST_CLEAR && !clr_all_ff) |->
      (clr_addr_ff[MEM_AW-1:INDEX_W] == new_page_ff))
      else $error("page clear left the page being taken");

   a_no_req_during_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_all_ff |-> !req_ready)
      else $error("request accepted during reset sweep");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != fptw_pkg::STATUS_DONE) |->
      (rsp_ff.translated_addr == '0))
      else $error("failed response carries an address");

   a_free_page_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fptw_pkg::ST_LINK) |-> (new_page_ff != '0))
      else $error("top-level page handed out from pool");

endmodule
